FILE: sv/positional_ordered_list_macros.svh
// Assertion macros for the positional ordered list.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define POL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define POL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/pol_pkg.sv
// Package with the types and codes of the positional ordered list.
package pol_pkg;
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_PRED   = 3'd4,
    OP_SUCC   = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Shift command broadcast to every cell.
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_UP    = 2'd1,
    SH_DOWN  = 2'd2
  } shift_t;

  typedef struct packed {
    shift_t      shift;
    logic [31:0] key;
    logic [31:0] ins_value;
  } cell_ctl_t;
endpackage

FILE: sv/pol_cell.sv
// One storage cell of the list chain with its own comparator.
module pol_cell (
  input  logic               clk,
  input  pol_pkg::cell_ctl_t ctl,
  input  logic               sel_here,   // this cell's slot is the operation point
  input  logic               sel_after,  // this cell lies above the operation point
  input  logic [31:0]        from_below,
  input  logic [31:0]        from_above,
  output logic [31:0]        data,
  output logic               match
);
  import pol_pkg::*;

  logic [31:0] data_r;
  logic [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.shift)
      SH_UP: begin
        if (sel_here) begin
          data_nxt = ctl.ins_value;
        end else if (sel_after) begin
          data_nxt = from_below;
        end
      end
      SH_DOWN: begin
        if (sel_here || sel_after) begin
          data_nxt = from_above;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == ctl.key);
endmodule

FILE: sv/positional_ordered_list.sv
// Top level of the positional ordered list.
// A bounded list of signed 32-bit values held in a chain of CAPACITY cells,
// one entry per cell, each with its own equality comparator. A request is
// accepted when start is high and busy is low; busy then rises for one cycle
// and the result appears with out_valid high for exactly one cycle. No new
// request is taken while busy is high. The request is first registered; while
// it is pending, all cell matches and the position checks are evaluated and,
// for insert or delete, the cells above the operation point shift by one
// place and the cell at it is written or refilled, in a single step. The
// receiver cannot stall the result. Cells above the current count hold stale
// data that is never reported.
module positional_ordered_list #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_position,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_result_value,
  output logic [6:0]  out_found_position,
  output logic [6:0]  out_list_length,
  output logic        out_list_empty
);
  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Registered request.
  logic              pend_r;
  logic [2:0]        op_r;
  logic [7:0]        pos_r;
  logic [31:0]       val_r;
  logic [CW-1:0]     count_r, count_nxt;

  logic [1:0]        status_r, status_nxt;
  logic [31:0]       rval_r, rval_nxt;
  logic [6:0]        fpos_r, fpos_nxt;
  logic              ovalid_r;

  cell_ctl_t         ctl;
  logic [CAPACITY-1:0] sel_here, sel_after, match, live;
  logic [31:0]       cdata [CAPACITY];

  // Accept a new item only while no item is pending.
  assign busy = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
      count_r  <= '0;
    end else begin
      pend_r   <= start && !busy;
      ovalid_r <= pend_r;
      if (pend_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_op;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (pend_r) begin
      status_r <= status_nxt;
      rval_r   <= rval_nxt;
      fpos_r   <= fpos_nxt;
    end
  end

  // Position checks, widened so position plus one never wraps.
  logic [8:0] pos9, cnt9;
  logic       pos_ok_rd, pos_ok_ins, full;
  assign pos9       = {1'b0, pos_r};
  assign cnt9       = 9'(count_r);
  assign pos_ok_rd  = (pos9 >= 9'd1) && (pos9 <= cnt9);
  assign pos_ok_ins = (pos9 >= 9'd1) && (pos9 <= cnt9 + 9'd1);
  assign full       = (cnt9 >= 9'(CAPACITY));

  // Per-cell decode of the operation point and the live range.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      sel_here[k]  = (pos9 == 9'(k + 1));
      sel_after[k] = (pos9 < 9'(k + 1));
      live[k]      = (9'(k) < cnt9);
    end
  end

  always_comb begin
    ctl.key       = val_r;
    ctl.ins_value = val_r;
    ctl.shift     = SH_HOLD;
    if (pend_r) begin
      case (op_r)
        OP_INSERT: if (pos_ok_ins && !full) ctl.shift = SH_UP;
        OP_DELETE: if (pos_ok_rd) ctl.shift = SH_DOWN;
        default:   ctl.shift = SH_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] below, above;
    if (g == 0) begin : g_lo
      assign below = '0;
    end else begin : g_mid
      assign below = cdata[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign above = cdata[g];
    end else begin : g_top
      assign above = cdata[g+1];
    end
    pol_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel_here   (sel_here[g]),
      .sel_after  (sel_after[g]),
      .from_below (below),
      .from_above (above),
      .data       (cdata[g]),
      .match      (match[g])
    );
  end

  // First-match search over the cell chain; the list is small and the
  // priority scan runs over independent match bits.
  always_comb begin
    logic fnd, pfnd, sfnd;
    logic [31:0] pv, sv;
    logic [6:0] fp;
    logic [31:0] gv;
    fnd = 1'b0; pfnd = 1'b0; sfnd = 1'b0;
    pv = '0; sv = '0; fp = '0; gv = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (live[k] && match[k]) begin
        fnd = 1'b1;
        fp  = 7'(k + 1);
      end
      if (sel_here[k]) begin
        gv = cdata[k];
      end
    end
    for (int k = CAPACITY - 1; k >= 1; k--) begin
      if (live[k] && match[k]) begin
        pfnd = 1'b1;
        pv   = cdata[k-1];
      end
    end
    for (int k = CAPACITY - 2; k >= 0; k--) begin
      if (live[k+1] && match[k]) begin
        sfnd = 1'b1;
        sv   = cdata[k+1];
      end
    end

    status_nxt = ST_ERR;
    rval_nxt   = '0;
    fpos_nxt   = '0;
    count_nxt  = count_r;
    case (op_r)
      OP_INSERT: begin
        if (pos_ok_ins) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_OK;
            count_nxt  = count_r + CW'(1);
          end
        end
      end
      OP_DELETE: begin
        if (pos_ok_rd) begin
          status_nxt = ST_OK;
          rval_nxt   = gv;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_GET: begin
        if (pos_ok_rd) begin
          status_nxt = ST_OK;
          rval_nxt   = gv;
        end
      end
      OP_FIND: begin
        if (fnd) begin
          status_nxt = ST_OK;
          fpos_nxt   = fp;
        end
      end
      OP_PRED: begin
        if (pfnd) begin
          status_nxt = ST_OK;
          rval_nxt   = pv;
        end
      end
      OP_SUCC: begin
        if (sfnd) begin
          status_nxt = ST_OK;
          rval_nxt   = sv;
        end
      end
      default: status_nxt = ST_ERR;
    endcase
  end

  assign out_valid          = ovalid_r;
  assign out_status         = status_r;
  assign out_result_value   = rval_r;
  assign out_found_position = fpos_r;
  assign out_list_length    = 7'(count_r);
  assign out_list_empty     = (count_r == '0);

  `include "positional_ordered_list_macros.svh"

  `POL_ASSERT_NEXT(a_result_follows, clk, rst_n, pend_r, out_valid, "result missing")
  `POL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, 9'(count_r) <= 9'(CAPACITY), "count over")
  `POL_ASSERT_IMPL(a_no_overlap, clk, rst_n, pend_r, !out_valid, "items overlap")
endmodule
